// ===== rtl/ucfd_pkg.sv =====
// ----------------------------------------------------------------------------
// ucfd_pkg
// Shared types and constants for the serial-to-CAN frame deframer.
// ----------------------------------------------------------------------------
package ucfd_pkg;

	// Framing bytes of the serial protocol.
	localparam logic [7:0] HDR_BYTE = 8'h40;
	localparam logic [7:0] TRL_BYTE = 8'h1A;
	localparam logic [7:0] TYPE_STD = 8'h00;
	localparam logic [7:0] TYPE_EXT = 8'h08;

	// Length overhead of each frame type, and payload limit.
	localparam logic [7:0] STD_OVERHEAD = 8'd3;
	localparam logic [7:0] EXT_OVERHEAD = 8'd5;
	localparam logic [7:0] MAX_DATA     = 8'd8;

	// Identifier masks.
	localparam logic [28:0] STD_ID_MASK = 29'h0000_07FF;
	localparam logic [28:0] EXT_ID_MASK = 29'h1FFF_FFFF;

	// Result status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_TRL = 2'd1;
	localparam logic [1:0] ST_BAD_TYP = 2'd2;
	localparam logic [1:0] ST_BAD_LEN = 2'd3;

	// Kinds of work that the front part hands to the back part.
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_ID    = 2'd1;
	localparam logic [1:0] KIND_DATA  = 2'd2;
	localparam logic [1:0] KIND_LAST  = 2'd3;

	// One queue entry: a classified byte plus the verdict for the last byte.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [2:0] idx;
		logic [1:0] status;
		logic       ext;
		logic [3:0] dlen;
	} ucfd_entry_t;

endpackage

// ===== rtl/ucfd_front.sv =====
// ----------------------------------------------------------------------------
// ucfd_front
// Accepts received bytes, tracks the frame position and classifies each byte.
// ----------------------------------------------------------------------------
module ucfd_front
	import ucfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  rx_byte,
	output logic        push,
	output ucfd_entry_t push_entry
);

	logic       in_frame_q;
	logic [8:0] pos_q;
	logic [7:0] len_q;
	logic [7:0] type_q;

	logic [8:0] last_pos;
	logic [8:0] k;
	logic [8:0] idlen;
	logic [8:0] dk;
	logic [7:0] ty;
	logic       ty_ext;
	logic [7:0] ovh;
	logic [7:0] dlen_full;

	// Position arithmetic for the current byte.
	always_comb begin
		last_pos  = {1'b0, len_q} + 9'd2;
		k         = pos_q - 9'd3;
		idlen     = (type_q == TYPE_EXT) ? 9'd4 : 9'd2;
		dk        = k - idlen;
		ty        = (pos_q == 9'd2) ? rx_byte : type_q;
		ty_ext    = (ty == TYPE_EXT);
		ovh       = ty_ext ? EXT_OVERHEAD : STD_OVERHEAD;
		dlen_full = len_q - ovh;
	end

	// Classify the accepted byte into a queue entry.
	always_comb begin
		push              = 1'b0;
		push_entry.kind   = KIND_START;
		push_entry.data   = rx_byte;
		push_entry.idx    = dk[2:0];
		push_entry.status = ST_OK;
		push_entry.ext    = ty_ext;
		push_entry.dlen   = dlen_full[3:0];
		if (accept) begin
			if (!in_frame_q) begin
				push = (rx_byte == HDR_BYTE);
			end else if (pos_q <= 9'd1) begin
				push = 1'b0;
			end else if (pos_q >= last_pos) begin
				push            = 1'b1;
				push_entry.kind = KIND_LAST;
				if (rx_byte != TRL_BYTE) begin
					push_entry.status = ST_BAD_TRL;
				end else if (ty != TYPE_STD && ty != TYPE_EXT) begin
					push_entry.status = ST_BAD_TYP;
				end else if (len_q < ovh || dlen_full > MAX_DATA) begin
					push_entry.status = ST_BAD_LEN;
				end
			end else if (pos_q == 9'd2) begin
				push = 1'b0;
			end else if (k < idlen) begin
				push            = 1'b1;
				push_entry.kind = KIND_ID;
			end else begin
				push            = (dk < {1'b0, MAX_DATA});
				push_entry.kind = KIND_DATA;
			end
		end
	end

	// Frame position state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			len_q      <= '0;
			type_q     <= '0;
		end else if (accept) begin
			if (!in_frame_q) begin
				if (rx_byte == HDR_BYTE) begin
					in_frame_q <= 1'b1;
					pos_q      <= 9'd1;
					len_q      <= '0;
					type_q     <= '0;
				end
			end else if (pos_q <= 9'd1) begin
				len_q <= rx_byte;
				pos_q <= 9'd2;
			end else if (pos_q >= last_pos) begin
				in_frame_q <= 1'b0;
				pos_q      <= '0;
			end else begin
				if (pos_q == 9'd2) begin
					type_q <= rx_byte;
				end
				pos_q <= pos_q + 9'd1;
			end
		end
	end

endmodule

// ===== rtl/ucfd_queue.sv =====
// ----------------------------------------------------------------------------
// ucfd_queue
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
module ucfd_queue
	import ucfd_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  ucfd_entry_t push_entry,
	input  logic        pop,
	output ucfd_entry_t head,
	output logic        not_empty,
	output logic        full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ucfd_entry_t    mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == CW'(DEPTH));

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/ucfd_back.sv =====
// ----------------------------------------------------------------------------
// ucfd_back
// Assembles identifier and payload and loads finished results for output.
// ----------------------------------------------------------------------------
module ucfd_back
	import ucfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ucfd_entry_t head,
	input  logic        not_empty,
	output logic        pop,
	output logic        valid,
	input  logic        stall,
	output logic [1:0]  status,
	output logic        is_extended,
	output logic [28:0] frame_id,
	output logic [3:0]  dlc,
	output logic [63:0] payload
);

	logic [31:0] id_q;
	logic [63:0] pl_q;
	logic        valid_q;
	logic [1:0]  status_q;
	logic        ext_q;
	logic [28:0] id_out_q;
	logic [3:0]  dlen_q;
	logic [63:0] pl_out_q;
	logic        load_ok;
	logic        load;

	// The output register takes a new result when empty or being drained.
	assign load_ok = !valid_q || !stall;
	assign pop     = not_empty && (head.kind != KIND_LAST || load_ok);
	assign load    = pop && head.kind == KIND_LAST;

	// Identifier and payload accumulation.
	always_ff @(posedge clk) begin
		if (pop) begin
			case (head.kind)
				KIND_START: begin
					id_q <= '0;
					pl_q <= '0;
				end
				KIND_ID: begin
					id_q <= {id_q[23:0], head.data};
				end
				KIND_DATA: begin
					pl_q[{head.idx, 3'b000} +: 8] <= head.data;
				end
				default: begin
				end
			endcase
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= head.status;
			if (head.status == ST_OK) begin
				ext_q    <= head.ext;
				id_out_q <= id_q[28:0] & (head.ext ? EXT_ID_MASK : STD_ID_MASK);
				dlen_q   <= head.dlen;
				pl_out_q <= pl_q;
			end else begin
				ext_q    <= 1'b0;
				id_out_q <= '0;
				dlen_q   <= '0;
				pl_out_q <= '0;
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ok) begin
			valid_q <= load;
		end
	end

	assign valid       = valid_q;
	assign status      = status_q;
	assign is_extended = ext_q;
	assign frame_id    = id_out_q;
	assign dlc         = dlen_q;
	assign payload     = pl_out_q;

endmodule

// ===== rtl/uart_can_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// uart_can_frame_deframer_unit
// Rebuilds CAN frames from the byte stream of a serial-to-CAN converter.
// ----------------------------------------------------------------------------
// Input channel: one received byte per item on rx_byte, moved when in_valid
// is high and in_stall is low. Bytes are dropped until the header 0x40; the
// frame then runs length byte, type, identifier, data and the 0x1A trailer.
// Output channel: one item per frame, on out_valid and out_stall, carrying
// status, is_extended, frame_id, dlc and payload. Error items have all
// fields but status at zero.
// Throughput: one byte per cycle while the queue has room, else in_stall holds
// the input. The front part classifies each byte in the cycle it is accepted;
// a queue of QUEUE_DEPTH entries feeds the back part, which retires one entry
// per cycle, but holds a trailer entry while out_stall keeps the output
// register full; a trailer entry passes through the queue into that register.
// Stalls: while out_stall holds, the result waits in the output register, the
// back part keeps assembling the next frame, and in_stall rises only once the
// queue fills. Reset clears the position state, the queue and out_valid; the
// block starts out hunting for a header.
// ----------------------------------------------------------------------------
module uart_can_frame_deframer_unit
	import ucfd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        is_extended,
	output logic [28:0] frame_id,
	output logic [3:0]  dlc,
	output logic [63:0] payload
);

	logic        accept;
	logic        push;
	ucfd_entry_t push_entry;
	logic        pop;
	ucfd_entry_t head;
	logic        not_empty;
	logic        full;

	// Input is taken whenever the queue has room.
	assign in_stall = full;
	assign accept   = in_valid && !full;

	ucfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.rx_byte    (rx_byte),
		.push       (push),
		.push_entry (push_entry)
	);

	ucfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.not_empty  (not_empty),
		.full       (full)
	);

	ucfd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.not_empty   (not_empty),
		.pop         (pop),
		.valid       (out_valid),
		.stall       (out_stall),
		.status      (status),
		.is_extended (is_extended),
		.frame_id    (frame_id),
		.dlc         (dlc),
		.payload     (payload)
	);

endmodule

// ===== tb/uart_can_frame_deframer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_can_frame_deframer_unit_tb
// Self-checking bench for the serial-to-CAN frame deframer.
// ----------------------------------------------------------------------------
// Serial bytes are fed in one item at a time, and a scoreboard class tracks
// the framing state to predict every result item. The stream is mostly
// well-formed standard and extended frames with random content, mixed with
// bad trailers, bad type bytes, bad lengths, very short and very long frames
// and stray bytes between frames. Both sides idle and stall at random, the
// receiver once holds off long enough to back the block up, and the sender
// pauses for the results to drain more than once.
// ----------------------------------------------------------------------------
module uart_can_frame_deframer_unit_tb;
	import ucfd_pkg::*;

	// One result item as seen on the output ports.
	typedef struct packed {
		logic [1:0]  status;
		logic        ext;
		logic [28:0] id;
		logic [3:0]  dlen;
		logic [63:0] data;
	} frame_result_t;

	// How the data bytes of a generated frame are filled.
	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

	// Tracks the framing state and holds the results still to come.
	class frame_scoreboard;
		bit            in_frame;
		logic [7:0]    frame_len;
		logic [8:0]    pos;
		logic [7:0]    type_b;
		logic [31:0]   id_acc;
		logic [63:0]   data_acc;
		frame_result_t pending_frames[$];
		int            mismatches;
		int            checked;
		int            by_status[4];

		function int pending();
			return pending_frames.size();
		endfunction

		// Advance the framing state by one accepted byte.
		function void predict_byte(logic [7:0] b);
			logic [8:0]    last_pos;
			logic [7:0]    ty;
			logic [7:0]    ovh;
			int            id_n;
			int            k;
			frame_result_t r;
			if (!in_frame) begin
				if (b == HDR_BYTE) begin
					in_frame = 1'b1;
					pos = 9'd1;
					frame_len = 8'd0;
					type_b = 8'd0;
					id_acc = 32'd0;
					data_acc = 64'd0;
				end
				return;
			end
			if (pos <= 9'd1) begin
				frame_len = b;
				pos = 9'd2;
				return;
			end
			last_pos = {1'b0, frame_len} + 9'd2;
			if (pos >= last_pos) begin
				// Trailer: with a zero length it doubles as the type byte.
				ty = (pos == 9'd2) ? b : type_b;
				in_frame = 1'b0;
				pos = 9'd0;
				r = '0;
				if (b != TRL_BYTE) begin
					r.status = ST_BAD_TRL;
				end else if (ty != TYPE_STD && ty != TYPE_EXT) begin
					r.status = ST_BAD_TYP;
				end else begin
					ovh = (ty == TYPE_EXT) ? EXT_OVERHEAD : STD_OVERHEAD;
					if (frame_len < ovh || frame_len - ovh > MAX_DATA) begin
						r.status = ST_BAD_LEN;
					end else begin
						r.status = ST_OK;
						r.ext = (ty == TYPE_EXT);
						r.id = id_acc[28:0] & (r.ext ? EXT_ID_MASK : STD_ID_MASK);
						r.dlen = 4'(frame_len - ovh);
						r.data = data_acc;
					end
				end
				pending_frames.push_back(r);
				by_status[r.status]++;
				return;
			end
			if (pos == 9'd2) begin
				type_b = b;
			end else begin
				id_n = (type_b == TYPE_EXT) ? 4 : 2;
				k = int'(pos) - 3;
				if (k < id_n)
					id_acc = {id_acc[23:0], b};
				else if (k - id_n < int'(MAX_DATA))
					data_acc[8 * (k - id_n) +: 8] = b;
			end
			pos = pos + 9'd1;
		endfunction

		// Compare one accepted result with the oldest prediction.
		function void check_result(frame_result_t got);
			frame_result_t want;
			checked++;
			if (pending_frames.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result with no frame pending: st=%0d ext=%0d id=%h",
						got.status, got.ext, got.id);
				return;
			end
			want = pending_frames.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: result %0d differs", checked);
					$display("  expected st=%0d ext=%0d id=%h len=%0d data=%h",
						want.status, want.ext, want.id, want.dlen, want.data);
					$display("  actual   st=%0d ext=%0d id=%h len=%0d data=%h",
						got.status, got.ext, got.id, got.dlen, got.data);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic        is_extended;
	logic [28:0] frame_id;
	logic [3:0]  dlc;
	logic [63:0] payload;

	frame_scoreboard sb;
	logic [7:0]      byte_q[$];
	bit              calm = 1'b0;
	int              hold_starts = 0;
	int              hold_served = 0;
	int              hold_left = 0;
	int              framed_bytes = 0;
	int              noise_bytes = 0;

	uart_can_frame_deframer_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.is_extended (is_extended),
		.frame_id    (frame_id),
		.dlc         (dlc),
		.payload     (payload)
	);

	always #5 clk = ~clk;

	// Receiver: random stalls, plus one long hold-off when requested.
	always @(negedge clk) begin
		if (hold_starts != hold_served) begin
			hold_served = hold_starts;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 26);
		end
	end

	// Check every result item accepted at the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_result({status, is_extended, frame_id, dlc, payload});
	end

	// Pick a data byte; random fill leans toward the header and trailer values.
	function automatic logic [7:0] data_byte(fill_t fill);
		int sel;
		sel = $urandom_range(99);
		if (fill == FILL_ZERO)
			return 8'h00;
		if (fill == FILL_ONES)
			return 8'hFF;
		if (sel < 5)
			return HDR_BYTE;
		if (sel < 10)
			return TRL_BYTE;
		return 8'($urandom_range(255));
	endfunction

	// Queue one frame of length len; the body is cut or padded to len bytes.
	task automatic queue_frame(input logic [7:0] ty, input int len, input logic [31:0] id,
			input fill_t fill, input logic [7:0] trl);
		int         id_n;
		logic [7:0] b;
		id_n = (ty == TYPE_EXT) ? 4 : 2;
		byte_q.push_back(HDR_BYTE);
		byte_q.push_back(8'(len));
		for (int i = 0; i < len; i++) begin
			if (i == 0)
				b = ty;
			else if (i <= id_n)
				b = id[8 * (id_n - i) +: 8];
			else
				b = data_byte(fill);
			byte_q.push_back(b);
		end
		byte_q.push_back(trl);
		framed_bytes += len + 3;
	endtask

	// Any byte except the given one.
	function automatic logic [7:0] other_than(logic [7:0] avoid);
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == avoid);
		return b;
	endfunction

	// Queue a random frame: mostly good, the rest broken in various ways.
	task automatic queue_random_frame();
		int         sel;
		int         len;
		int         ovh;
		logic [7:0] ty;
		logic [7:0] trl;
		sel = $urandom_range(99);
		ty = $urandom_range(1) ? TYPE_EXT : TYPE_STD;
		ovh = (ty == TYPE_EXT) ? int'(EXT_OVERHEAD) : int'(STD_OVERHEAD);
		len = ovh + $urandom_range(8);
		trl = TRL_BYTE;
		if (sel < 70) begin
			// Well-formed frame.
		end else if (sel < 79) begin
			trl = other_than(TRL_BYTE);
		end else if (sel < 86) begin
			do
				ty = 8'($urandom_range(255));
			while (ty == TYPE_STD || ty == TYPE_EXT);
			len = $urandom_range(15);
		end else if (sel < 94) begin
			len = $urandom_range(1) ? $urandom_range(ovh - 1) : ovh + 9 + $urandom_range(6);
		end else if (sel < 97) begin
			len = 0;
			trl = $urandom_range(1) ? TRL_BYTE : other_than(TRL_BYTE);
		end else if (sel < 98) begin
			len = $urandom_range(1) ? 255 : $urandom_range(14, 120);
		end else begin
			// Stray bytes ahead of a good frame.
			repeat ($urandom_range(1, 6)) begin
				byte_q.push_back(8'($urandom_range(255)));
				noise_bytes++;
			end
		end
		queue_frame(ty, len, $urandom(), FILL_RANDOM, trl);
	endtask

	// Offer one item; starts and ends at a falling edge.
	task automatic send_byte(input logic [7:0] b);
		while (!calm && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (in_stall);
		sb.predict_byte(b);
		@(negedge clk);
	endtask

	task automatic send_queued();
		while (byte_q.size() != 0)
			send_byte(byte_q.pop_front());
	endtask

	// Stop offering items until every predicted result has arrived.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (sb.pending() != 0);
	endtask

	// Run limit, far above the slowest correct run.
	initial begin
		#5_000_000;
		$display("Timed out with %0d results outstanding", sb.pending());
		$display("FAIL uart_can_frame_deframer_unit");
		$finish;
	end

	initial begin
		bit hold_done;
		bit pause_done;
		sb = new();
		hold_done = 1'b0;
		pause_done = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed frames: zero length with and without the trailer value,
		// a bad type byte, an all-zero standard frame and an all-ones
		// extended frame.
		queue_frame(TYPE_STD, 0, 32'h0, FILL_ZERO, TRL_BYTE);
		queue_frame(TYPE_STD, 0, 32'h0, FILL_ZERO, 8'h00);
		queue_frame(8'hFF, 1, 32'h0, FILL_ZERO, TRL_BYTE);
		queue_frame(TYPE_STD, 3, 32'h0, FILL_ZERO, TRL_BYTE);
		queue_frame(TYPE_EXT, 9, 32'hFFFF_FFFF, FILL_ONES, TRL_BYTE);
		send_queued();
		wait_drained();

		// Random frames with a calm stretch, a long hold-off and a pause.
		while (framed_bytes < 1000) begin
			calm = (framed_bytes >= 300 && framed_bytes < 500);
			if (!hold_done && framed_bytes >= 600) begin
				hold_starts++;
				hold_done = 1'b1;
			end
			if (!pause_done && framed_bytes >= 800) begin
				wait_drained();
				pause_done = 1'b1;
			end
			queue_random_frame();
			send_queued();
		end
		calm = 1'b0;

		wait_drained();
		repeat (20) @(negedge clk);
		$display("Drove %0d frame bytes and %0d stray bytes; checked %0d results",
			framed_bytes, noise_bytes, sb.checked);
		$display("(%0d good, %0d bad trailer, %0d bad type, %0d bad length).",
			sb.by_status[ST_OK], sb.by_status[ST_BAD_TRL], sb.by_status[ST_BAD_TYP],
			sb.by_status[ST_BAD_LEN]);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("PASS uart_can_frame_deframer_unit");
		end else begin
			$display("%0d mismatches, %0d results never arrived", sb.mismatches,
				sb.pending());
			$display("FAIL uart_can_frame_deframer_unit");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ucfd_pkg.sv
rtl/ucfd_front.sv
rtl/ucfd_queue.sv
rtl/ucfd_back.sv
rtl/uart_can_frame_deframer_unit.sv
tb/uart_can_frame_deframer_unit_tb.sv
